// ----- rtl/core/sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, constants and the band edge table of the band meter.
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int NUM_BINS   = 128;
    localparam int NUM_BAND   = 16;
    localparam int MAG_W      = 24;
    localparam int LVL_W      = 16;
    localparam int BIN_W      = 7;
    localparam int BAND_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_GATE     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_SPAN     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_RATIO    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 4'd7;

    localparam logic [BIN_W-1:0] BASS_LO = 7'd2;
    localparam logic [BIN_W-1:0] BASS_HI = 7'd7;

    localparam logic [LVL_W-1:0] LEVEL_ONE   = 16'hFFFF;
    localparam logic [LVL_W-1:0] LEVEL_CUT   = 16'd2622;
    localparam logic [LVL_W-1:0] VIB_CUT     = 16'd1311;
    localparam logic [LVL_W-1:0] AVG_KEEP    = 16'd52429;
    localparam logic [LVL_W-1:0] AVG_NEW     = 16'd13107;
    localparam logic [LVL_W-1:0] VIB_KEEP    = 16'd19661;
    localparam logic [LVL_W-1:0] GLOW_KEEP   = 16'd53740;
    localparam logic [LVL_W-1:0] DRIVE_RECIP = 16'd65281;   // 2^24 / 257, rounded up
    localparam logic [17:0]      BEAT_MIN    = 18'd7864;

    typedef logic [7:0] t_edge;

    localparam t_edge BAND_LO [NUM_BAND] = '{
        8'd3, 8'd3, 8'd4, 8'd6, 8'd7, 8'd9, 8'd12, 8'd15,
        8'd19, 8'd24, 8'd31, 8'd39, 8'd50, 8'd63, 8'd80, 8'd101
    };
    localparam t_edge BAND_HI [NUM_BAND] = '{
        8'd4, 8'd4, 8'd6, 8'd7, 8'd9, 8'd12, 8'd15, 8'd19,
        8'd24, 8'd31, 8'd39, 8'd50, 8'd63, 8'd80, 8'd101, 8'd128
    };

    typedef struct packed {
        logic [MAG_W-1:0] noise_floor;
        logic [MAG_W-1:0] full_scale;
        logic [15:0]      attack;
        logic [15:0]      decay;
        logic [MAG_W-1:0] bass_gate;
        logic [MAG_W-1:0] bass_span;
        logic [9:0]       beat_ratio;
        logic [15:0]      cooldown;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_DIV_BASS,
        OP_DIV_BAND,
        OP_DIV_STEP,
        OP_BL,
        OP_AVG1,
        OP_AVG2,
        OP_AVG_WB,
        OP_THR,
        OP_BEAT,
        OP_VIB,
        OP_GLOW,
        OP_DRIVE,
        OP_TGT,
        OP_LVL1,
        OP_LVL2,
        OP_LVL_WB,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic              take;
        t_op               op;
        logic [BAND_W-1:0] band;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

// ----- rtl/core/sbm_cfg.sv -----
// ----------------------------------------------------------------------------
// sbm_cfg
// Configuration register file, written one request at a time.
// ----------------------------------------------------------------------------
module sbm_cfg import sbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_floor <= 24'd1500;
            r_cfg.full_scale  <= 24'd18000;
            r_cfg.attack      <= 16'd45875;
            r_cfg.decay       <= 16'd49152;
            r_cfg.bass_gate   <= 24'd800;
            r_cfg.bass_span   <= 24'd8000;
            r_cfg.beat_ratio  <= 10'd333;
            r_cfg.cooldown    <= 16'd60;
        end else if (i_wr) begin
            case (i_index)
                CFG_NOISE_FLOOR: r_cfg.noise_floor <= i_data;
                CFG_FULL_SCALE:  r_cfg.full_scale  <= i_data;
                CFG_ATTACK:      r_cfg.attack      <= i_data[15:0];
                CFG_DECAY:       r_cfg.decay       <= i_data[15:0];
                CFG_BASS_GATE:   r_cfg.bass_gate   <= i_data;
                CFG_BASS_SPAN:   r_cfg.bass_span   <= i_data;
                CFG_BEAT_RATIO:  r_cfg.beat_ratio  <= i_data[9:0];
                CFG_COOLDOWN:    r_cfg.cooldown    <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/sbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbm_ctrl
// Sequencer: bin intake, bass and beat update, then per-band scoring.
// ----------------------------------------------------------------------------
module sbm_ctrl import sbm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_frame_end,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_BDIV, S_DIV, S_BL, S_AVG1, S_AVG2, S_AVG_WB, S_THR, S_BEAT,
        S_VIB, S_GLOW, S_DRIVE, S_TDIV, S_TGT, S_LVL1, S_LVL2, S_LVL_WB, S_EMIT
    } t_state;

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BAND - 1);

    t_state              r_state;
    logic [BAND_W-1:0]   r_band;
    logic                r_bass;
    logic                r_valid;

    always_comb begin
        o_cmd.take = (r_state == S_IDLE) && i_valid;
        o_cmd.band = r_band;
        case (r_state)
            S_BDIV:   o_cmd.op = OP_DIV_BASS;
            S_DIV:    o_cmd.op = OP_DIV_STEP;
            S_BL:     o_cmd.op = OP_BL;
            S_AVG1:   o_cmd.op = OP_AVG1;
            S_AVG2:   o_cmd.op = OP_AVG2;
            S_AVG_WB: o_cmd.op = OP_AVG_WB;
            S_THR:    o_cmd.op = OP_THR;
            S_BEAT:   o_cmd.op = OP_BEAT;
            S_VIB:    o_cmd.op = OP_VIB;
            S_GLOW:   o_cmd.op = OP_GLOW;
            S_DRIVE:  o_cmd.op = OP_DRIVE;
            S_TDIV:   o_cmd.op = OP_DIV_BAND;
            S_TGT:    o_cmd.op = OP_TGT;
            S_LVL1:   o_cmd.op = OP_LVL1;
            S_LVL2:   o_cmd.op = OP_LVL2;
            S_LVL_WB: o_cmd.op = OP_LVL_WB;
            S_EMIT:   o_cmd.op = (!i_stall && r_band == LAST_BAND) ? OP_CLEAR : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_band  <= '0;
            r_bass  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:   if (i_valid && i_frame_end) r_state <= S_BDIV;
                S_BDIV: begin
                    r_bass  <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV:    if (i_stat.div_last) r_state <= r_bass ? S_BL : S_TGT;
                S_BL:     r_state <= S_AVG1;
                S_AVG1:   r_state <= S_AVG2;
                S_AVG2:   r_state <= S_AVG_WB;
                S_AVG_WB: r_state <= S_THR;
                S_THR:    r_state <= S_BEAT;
                S_BEAT:   r_state <= S_VIB;
                S_VIB:    r_state <= S_GLOW;
                S_GLOW:   r_state <= S_DRIVE;
                S_DRIVE: begin
                    r_band  <= '0;
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    r_bass  <= 1'b0;
                    r_state <= S_DIV;
                end
                S_TGT:    r_state <= S_LVL1;
                S_LVL1:   r_state <= S_LVL2;
                S_LVL2:   r_state <= S_LVL_WB;
                S_LVL_WB: begin
                    r_valid <= 1'b1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        if (r_band == LAST_BAND) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_band  <= r_band + 1'b1;
                            r_state <= S_TDIV;
                        end
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ----- rtl/core/sbm_datapath.sv -----
// ----------------------------------------------------------------------------
// sbm_datapath
// Peak registers, shared restoring divider, shared multiplier and levels.
// ----------------------------------------------------------------------------
module sbm_datapath import sbm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [BIN_W-1:0]  i_bin_index,
    input  logic [MAG_W-1:0]  i_magnitude,
    input  logic [31:0]       i_time_ms,
    output logic [BAND_W-1:0] o_band_number,
    output logic [LVL_W-1:0]  o_band_level,
    output logic              o_beat_seen,
    output logic [7:0]        o_vibration_drive,
    output logic [LVL_W-1:0]  o_glow_level,
    output logic              o_last_band
);

    logic [MAG_W-1:0] r_band_peak [NUM_BAND];
    logic [LVL_W-1:0] r_smooth    [NUM_BAND];
    logic [MAG_W-1:0] r_bass_peak;
    logic [LVL_W-1:0] r_avg;
    logic [LVL_W-1:0] r_vib;
    logic [LVL_W-1:0] r_glow;
    logic [31:0]      r_last;
    logic [31:0]      r_now;
    logic             r_beat;
    logic [7:0]       r_drive;

    logic [MAG_W-1:0] r_rem;
    logic [MAG_W-1:0] r_den;
    logic [LVL_W-1:0] r_quo;
    logic             r_force;
    logic [LVL_W-1:0] r_force_val;
    logic [3:0]       r_div_cnt;
    logic [LVL_W-1:0] r_bl;
    logic [LVL_W-1:0] r_tgt;
    logic [33:0]      r_acc;

    logic [MAG_W-1:0] den_full, den_span, sel_peak, bass_num;
    logic [LVL_W-1:0] sel_lvl, lvl_new, vib_n, glow_n, div_res;
    logic             rise, beat_n;
    logic [16:0]      mul_a, mul_b;
    logic [33:0]      prod;
    logic [MAG_W:0]   rem2;
    logic             rem_ge;
    logic [17:0]      thresh;
    logic [31:0]      dt;

    assign den_full = (i_cfg.full_scale == '0) ? MAG_W'(1) : i_cfg.full_scale;
    assign den_span = (i_cfg.bass_span == '0) ? MAG_W'(1) : i_cfg.bass_span;
    assign sel_peak = r_band_peak[i_cmd.band];
    assign sel_lvl  = r_smooth[i_cmd.band];
    assign bass_num = r_bass_peak - i_cfg.bass_gate;
    assign div_res  = r_force ? r_force_val : r_quo;
    assign rise     = r_tgt > sel_lvl;
    assign rem2     = {r_rem, 1'b0};
    assign rem_ge   = rem2 >= {1'b0, r_den};
    assign thresh   = (r_acc[25:8] < BEAT_MIN) ? BEAT_MIN : r_acc[25:8];
    assign dt       = r_now - r_last;
    assign beat_n   = ({2'b00, r_bl} > thresh) && (dt > {16'd0, i_cfg.cooldown});
    assign lvl_new  = r_acc[31:16];
    assign vib_n    = prod[31:16];
    assign glow_n   = prod[31:16];

    always_comb begin
        case (i_cmd.op)
            OP_AVG1: begin
                mul_a = {1'b0, r_avg};
                mul_b = {1'b0, AVG_KEEP};
            end
            OP_AVG2: begin
                mul_a = {1'b0, r_bl};
                mul_b = {1'b0, AVG_NEW};
            end
            OP_THR: begin
                mul_a = {1'b0, r_avg};
                mul_b = {7'd0, i_cfg.beat_ratio};
            end
            OP_VIB: begin
                mul_a = {1'b0, r_vib};
                mul_b = {1'b0, VIB_KEEP};
            end
            OP_GLOW: begin
                mul_a = {1'b0, r_glow};
                mul_b = {1'b0, GLOW_KEEP};
            end
            OP_DRIVE: begin
                mul_a = {1'b0, r_vib};
                mul_b = {1'b0, DRIVE_RECIP};
            end
            OP_LVL1: begin
                mul_a = {1'b0, sel_lvl};
                mul_b = rise ? (17'h10000 - {1'b0, i_cfg.attack}) : {1'b0, i_cfg.decay};
            end
            OP_LVL2: begin
                mul_a = {1'b0, r_tgt};
                mul_b = rise ? {1'b0, i_cfg.attack} : (17'h10000 - {1'b0, i_cfg.decay});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BAND; b++) begin
                r_band_peak[b] <= '0;
                r_smooth[b]    <= '0;
            end
            r_bass_peak <= '0;
            r_avg       <= '0;
            r_vib       <= '0;
            r_glow      <= '0;
            r_last      <= '0;
            r_beat      <= 1'b0;
            r_drive     <= '0;
        end else begin
            if (i_cmd.take && int'(i_bin_index) < NUM_BINS) begin
                for (int b = 0; b < NUM_BAND; b++) begin
                    if ({1'b0, i_bin_index} >= BAND_LO[b] && {1'b0, i_bin_index} < BAND_HI[b]
                        && i_magnitude > r_band_peak[b]) begin
                        r_band_peak[b] <= i_magnitude;
                    end
                end
                if (i_bin_index >= BASS_LO && i_bin_index < BASS_HI
                    && i_magnitude > r_bass_peak) begin
                    r_bass_peak <= i_magnitude;
                end
            end
            case (i_cmd.op)
                OP_AVG_WB: r_avg <= r_acc[31:16];
                OP_BEAT: begin
                    r_beat <= beat_n;
                    if (beat_n) r_last <= r_now;
                end
                OP_VIB:    r_vib  <= r_beat ? LEVEL_ONE : ((vib_n < VIB_CUT) ? '0 : vib_n);
                OP_GLOW:   r_glow <= r_beat ? LEVEL_ONE : ((glow_n < LEVEL_CUT) ? '0 : glow_n);
                OP_DRIVE:  r_drive <= prod[31:24];
                OP_LVL_WB: r_smooth[i_cmd.band] <= (lvl_new < LEVEL_CUT) ? '0 : lvl_new;
                OP_CLEAR: begin
                    for (int b = 0; b < NUM_BAND; b++) r_band_peak[b] <= '0;
                    r_bass_peak <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_now <= i_time_ms;
        case (i_cmd.op)
            OP_DIV_BASS: begin
                r_rem       <= bass_num;
                r_den       <= den_span;
                r_quo       <= '0;
                r_div_cnt   <= '0;
                r_force     <= !(r_bass_peak > i_cfg.bass_gate) || (bass_num >= den_span);
                r_force_val <= (r_bass_peak > i_cfg.bass_gate) ? LEVEL_ONE : '0;
            end
            OP_DIV_BAND: begin
                r_rem       <= sel_peak;
                r_den       <= den_full;
                r_quo       <= '0;
                r_div_cnt   <= '0;
                r_force     <= (sel_peak < i_cfg.noise_floor) || (sel_peak >= den_full);
                r_force_val <= (sel_peak < i_cfg.noise_floor) ? '0 : LEVEL_ONE;
            end
            OP_DIV_STEP: begin
                r_rem     <= rem_ge ? MAG_W'(rem2 - {1'b0, r_den}) : rem2[MAG_W-1:0];
                r_quo     <= {r_quo[LVL_W-2:0], rem_ge};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            OP_BL:   r_bl  <= div_res;
            OP_TGT:  r_tgt <= div_res;
            OP_AVG1, OP_THR, OP_LVL1: r_acc <= prod;
            OP_AVG2, OP_LVL2:         r_acc <= r_acc + prod;
            OP_LVL_WB: begin
                o_band_number     <= i_cmd.band;
                o_band_level      <= (lvl_new < LEVEL_CUT) ? '0 : lvl_new;
                o_beat_seen       <= r_beat;
                o_vibration_drive <= r_drive;
                o_glow_level      <= r_glow;
                o_last_band       <= (i_cmd.band == BAND_W'(NUM_BAND - 1));
            end
            default: ;
        endcase
    end

    assign o_stat.div_last = (r_div_cnt == 4'd15);

endmodule

// ----- rtl/core/spectrum_band_meter_beat_detector_unit.sv -----
// ----------------------------------------------------------------------------
// spectrum_band_meter_beat_detector_unit
// Log-band spectrum meter with bass beat detection, one bin per request.
// ----------------------------------------------------------------------------
// Throughput: a non-final bin is taken every cycle while the unit is idle.
// A frame-end bin starts the bass and beat work, then each of the 16 bands
// in turn (16-step shared divider, two multiply passes, write-back, output),
// and any output stall holds the sequence; no bin is taken until it ends.
// Reset: synchronous active low; levels, peaks, config and sequencer state to defaults.
module spectrum_band_meter_beat_detector_unit import sbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BIN_W-1:0]      i_bin_index,
    input  logic [MAG_W-1:0]      i_magnitude,
    input  logic                  i_frame_end,
    input  logic [31:0]           i_time_ms,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BAND_W-1:0]     o_band_number,
    output logic [LVL_W-1:0]      o_band_level,
    output logic                  o_beat_seen,
    output logic [7:0]            o_vibration_drive,
    output logic [LVL_W-1:0]      o_glow_level,
    output logic                  o_last_band,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    sbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_frame_end (i_frame_end),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sbm_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_bin_index       (i_bin_index),
        .i_magnitude       (i_magnitude),
        .i_time_ms         (i_time_ms),
        .o_band_number     (o_band_number),
        .o_band_level      (o_band_level),
        .o_beat_seen       (o_beat_seen),
        .o_vibration_drive (o_vibration_drive),
        .o_glow_level      (o_glow_level),
        .o_last_band       (o_last_band)
    );

endmodule

// ----- rtl/core/sbm_checker.sv -----
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks of the band meter, bound to the top level.
// ----------------------------------------------------------------------------
module sbm_checker import sbm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [BAND_W-1:0] o_band_number,
    input logic [LVL_W-1:0]  o_band_level,
    input logic              o_last_band
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_band_number, o_band_level}))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("bin request open while a result is pending");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result repeated without a gap");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_band == (o_band_number == BAND_W'(NUM_BAND - 1))))
        else $error("last band flag wrong");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind spectrum_band_meter_beat_detector_unit sbm_checker u_sbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_band_number (o_band_number),
    .o_band_level  (o_band_level),
    .o_last_band   (o_last_band)
);
